[rtl/sle_pkg.sv]
package sle_pkg;

    localparam int LINE_LEN_DEF = 32;
    localparam int CMDQ_DEPTH   = 2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_SP = 8'h20;

    typedef logic [1:0] cmd_kind_t;

    localparam cmd_kind_t CMD_CHAR = 2'd0;
    localparam cmd_kind_t CMD_BS   = 2'd1;
    localparam cmd_kind_t CMD_LF   = 2'd2;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

endpackage

[rtl/serial_line_editor_echo.sv]
// Channel   Handshake               Payload
// input     push / full             rx_byte
// result    empty / pop             out_kind, out_byte, last
// config    cfg_we (no wait)        cfg_wdata (echo enable)
//
// Results leave through the output register at one per cycle while the
// receiver pops or the register is empty; newline readout takes the line
// bytes from the line store read port. Reset clears the cursor, echo
// enable and all queues; the line store is not cleared. Either side may
// stall at will: the command queue lets the input side keep going while
// results wait, until the queue and the front holding register are full.
module serial_line_editor_echo #(
    parameter int LINE_LEN = sle_pkg::LINE_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       push,
    input  logic [7:0] rx_byte,
    output logic       full,
    output logic       out_kind,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       empty,
    input  logic       pop
);
    import sle_pkg::*;

    // front -> queue
    logic f_valid;
    cmd_t f_cmd;
    logic f_ready;

    // queue -> back
    logic q_valid;
    cmd_t q_cmd;
    logic q_take;

    // front: drops NUL and CR, classifies LF / BS / plain character
    sle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rx_byte   (rx_byte),
        .full      (full),
        .cmd_valid (f_valid),
        .cmd       (f_cmd),
        .cmd_ready (f_ready)
    );

    sle_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_cmd   (f_cmd),
        .push_ready (f_ready),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd),
        .pop_take   (q_take)
    );

    // back: line store, cursor, echo sequencing and line readout
    sle_back #(
        .LINE_LEN (LINE_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_take  (q_take),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .last      (last),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

[rtl/sle_front.sv]
module sle_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    rx_byte,
    output logic          full,
    output logic          cmd_valid,
    output sle_pkg::cmd_t cmd,
    input  logic          cmd_ready
);
    import sle_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    cmd_t cls;
    logic keep;
    logic accept;

    // NUL and CR produce no command at all
    always_comb
    begin
        keep     = (rx_byte != 8'h00) && (rx_byte != CH_CR);
        cls.data = rx_byte;
        priority if (rx_byte == CH_LF)
        begin
            cls.kind = CMD_LF;
        end
        else if (rx_byte == CH_BS)
        begin
            cls.kind = CMD_BS;
        end
        else
        begin
            cls.kind = CMD_CHAR;
        end
    end

    assign full            = hold_valid_reg && !cmd_ready;
    assign accept          = push && !full;
    assign hold_valid_next = accept ? keep : (hold_valid_reg && !cmd_ready);
    assign cmd_valid       = hold_valid_reg;
    assign cmd             = hold_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_cmd_reg <= cls;
        end
    end

endmodule

[rtl/sle_cmdq.sv]
module sle_cmdq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  sle_pkg::cmd_t push_cmd,
    output logic          push_ready,
    output logic          pop_valid,
    output sle_pkg::cmd_t pop_cmd,
    input  logic          pop_take
);
    import sle_pkg::*;

    localparam int AW = $clog2(CMDQ_DEPTH);

    cmd_t            slot_reg [CMDQ_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [AW:0]     count_reg;
    logic [AW:0]     count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != (AW+1)'(CMDQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_take && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/sle_back.sv]
module sle_back #(
    parameter int LINE_LEN = sle_pkg::LINE_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    input  logic          cmd_valid,
    input  sle_pkg::cmd_t cmd,
    output logic          cmd_take,
    output logic          out_kind,
    output logic [7:0]    out_byte,
    output logic          last,
    output logic          empty,
    input  logic          pop
);
    import sle_pkg::*;

    localparam int CUR_W = $clog2(LINE_LEN);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ECHO = 2'd1;
    localparam logic [1:0] S_LINE = 2'd2;

    localparam logic [1:0] EK_CHAR = 2'd0;
    localparam logic [1:0] EK_BS   = 2'd1;
    localparam logic [1:0] EK_CRLF = 2'd2;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    localparam logic [CUR_W-1:0] CUR_LAST = CUR_W'(LINE_LEN - 1);

    logic [7:0]       line_mem [LINE_LEN];
    logic [7:0]       rd_data_reg;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       step_reg, step_next;
    logic [1:0]       ekind_reg, ekind_next;
    logic [7:0]       ebyte_reg, ebyte_next;
    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [CUR_W-1:0] idx_reg, idx_next;
    logic             echo_en_reg;

    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_last_reg;
    logic [7:0]       out_byte_reg;

    logic             mem_we;
    logic             can_emit;
    logic             emit;
    logic             emit_kind;
    logic [7:0]       emit_byte;
    logic             emit_last;
    logic [7:0]       echo_byte;
    logic             echo_final;

    assign can_emit = !out_valid_reg || pop;

    always_comb
    begin
        echo_byte  = ebyte_reg;
        echo_final = 1'b0;
        unique case (ekind_reg)
            EK_CHAR:
            begin
                echo_byte  = ebyte_reg;
                echo_final = 1'b1;
            end
            EK_BS:
            begin
                echo_byte  = (step_reg == 2'd1) ? CH_SP : CH_BS;
                echo_final = (step_reg == 2'd2);
            end
            EK_CRLF:
            begin
                echo_byte  = (step_reg == 2'd0) ? CH_CR : CH_LF;
                echo_final = (step_reg == 2'd1);
            end
            default:
            begin
                echo_final = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        ekind_next  = ekind_reg;
        ebyte_next  = ebyte_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        mem_we      = 1'b0;
        cmd_take    = 1'b0;
        emit        = 1'b0;
        emit_kind   = KIND_ECHO;
        emit_byte   = 8'h00;
        emit_last   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    step_next  = 2'd0;
                    ebyte_next = cmd.data;
                    unique case (cmd.kind)
                        CMD_CHAR:
                        begin
                            // last slot is overwritten once the line is full
                            mem_we = 1'b1;
                            if (cursor_reg != CUR_LAST)
                            begin
                                cursor_next = cursor_reg + 1'b1;
                            end
                            ekind_next = EK_CHAR;
                            if (echo_en_reg)
                            begin
                                state_next = S_ECHO;
                            end
                        end
                        CMD_BS:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - 1'b1;
                            end
                            ekind_next = EK_BS;
                            if (echo_en_reg)
                            begin
                                state_next = S_ECHO;
                            end
                        end
                        CMD_LF:
                        begin
                            idx_next   = '0;
                            ekind_next = EK_CRLF;
                            if (cursor_reg == '0 || echo_en_reg)
                            begin
                                state_next = S_ECHO;
                            end
                            else
                            begin
                                state_next = S_LINE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ECHO:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_ECHO;
                    emit_byte = echo_byte;
                    emit_last = echo_final && (ekind_reg != EK_CRLF);
                    if (echo_final)
                    begin
                        state_next = (ekind_reg == EK_CRLF) ? S_LINE : S_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            S_LINE:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_LINE;
                    if (idx_reg == cursor_reg)
                    begin
                        // terminator
                        emit_byte   = 8'h00;
                        emit_last   = 1'b1;
                        cursor_next = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        emit_byte = rd_data_reg;
                        idx_next  = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 2'd0;
            ekind_reg     <= EK_CHAR;
            cursor_reg    <= '0;
            idx_reg       <= '0;
            echo_en_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ekind_reg     <= ekind_next;
            cursor_reg    <= cursor_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                echo_en_reg <= cfg_wdata;
            end
        end
    end

    // read data is registered from the next index, so it holds the byte at the current index
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[cursor_reg] <= ebyte_next;
        end
        rd_data_reg <= line_mem[idx_next];
    end

    always_ff @(posedge clk)
    begin
        ebyte_reg <= ebyte_next;
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_kind = out_kind_reg;
    assign out_byte = out_byte_reg;
    assign last     = out_last_reg;

endmodule

[bench/tb_serial_line_editor_echo.sv]
`timescale 1ns / 1ps

module tb_serial_line_editor_echo;
    import sle_pkg::*;

    // Line editor bench: a short directed table, then random lines across
    // four handshake phases. Every accepted rx byte runs through the local
    // editor model; its bytes, or a typed row's own, queue for in-order checks.

    localparam int          LINE_LEN    = LINE_LEN_DEF;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          SETTLE      = 60;       // > newline of a full line
    localparam logic [7:0]  NO_DATA     = 8'h00;
    localparam logic        KIND_ECHO   = 1'b0;
    localparam logic        KIND_LINE   = 1'b1;

    // {kind, byte} shorthands for the typed-in rows
    localparam logic [8:0]  ECHO_CR  = {KIND_ECHO, CH_CR};
    localparam logic [8:0]  ECHO_LF  = {KIND_ECHO, CH_LF};
    localparam logic [8:0]  ECHO_BS  = {KIND_ECHO, CH_BS};
    localparam logic [8:0]  ECHO_SP  = {KIND_ECHO, CH_SP};
    localparam logic [8:0]  LINE_END = {KIND_LINE, 8'h00};
    localparam logic [8:0]  NIL      = 9'h000;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } line_out_t;

    typedef enum logic {ROW_RX, ROW_ECHO} row_kind_t;

    // typed = 1: the n results in r are the expectation; otherwise the
    // model decides.
    typedef struct packed {
        row_kind_t        kind;
        logic [7:0]       data;
        logic             typed;
        logic [1:0]       n;
        logic [0:2][8:0]  r;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       push;
    logic [7:0] rx_byte;
    logic       full;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       last;
    logic       empty;
    logic       pop;

    // model state
    logic [7:0]  held_chars [LINE_LEN];
    int unsigned cur_pos = 0;
    logic        echo_on = 1'b0;

    line_out_t   due_bytes [$];
    int          err_cnt       = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_left     = 0;   // receiver hold-off, in cycles

    int phase_echo [4] = '{1, 0, 1, 0};
    int phase_send [4] = '{0, 55, 0, 19};
    int phase_stall[4] = '{0, 0, 55, 19};

    // Echo starts off after reset.
    stim_row_t plan [0:20] = '{
        '{ROW_RX,   NO_DATA, 1'b1, 2'd0, {NIL, NIL, NIL}},              // no data
        '{ROW_RX,   CH_CR,   1'b1, 2'd0, {NIL, NIL, NIL}},              // CR dropped
        '{ROW_RX,   CH_LF,   1'b1, 2'd3, {ECHO_CR, ECHO_LF, LINE_END}}, // empty line
        '{ROW_RX,   CH_BS,   1'b1, 2'd0, {NIL, NIL, NIL}},              // BS, empty
        '{ROW_ECHO, 8'h01,   1'b0, 2'd0, {NIL, NIL, NIL}},
        '{ROW_RX,   CH_BS,   1'b1, 2'd3, {ECHO_BS, ECHO_SP, ECHO_BS}},  // erase, empty
        '{ROW_RX,   8'hFF,   1'b1, 2'd1, {KIND_ECHO, 8'hFF, NIL, NIL}},
        '{ROW_RX,   8'h01,   1'b1, 2'd1, {KIND_ECHO, 8'h01, NIL, NIL}},
        '{ROW_RX,   8'h80,   1'b1, 2'd1, {KIND_ECHO, 8'h80, NIL, NIL}},
        '{ROW_RX,   8'h7F,   1'b1, 2'd1, {KIND_ECHO, 8'h7F, NIL, NIL}},
        '{ROW_RX,   CH_CR,   1'b1, 2'd0, {NIL, NIL, NIL}},              // CR, echo on
        '{ROW_RX,   NO_DATA, 1'b1, 2'd0, {NIL, NIL, NIL}},
        '{ROW_RX,   CH_BS,   1'b1, 2'd3, {ECHO_BS, ECHO_SP, ECHO_BS}},
        '{ROW_RX,   CH_LF,   1'b0, 2'd0, {NIL, NIL, NIL}},
        '{ROW_ECHO, 8'h00,   1'b0, 2'd0, {NIL, NIL, NIL}},
        '{ROW_RX,   8'h61,   1'b1, 2'd0, {NIL, NIL, NIL}},
        '{ROW_RX,   CH_LF,   1'b0, 2'd0, {NIL, NIL, NIL}},              // no CR LF
        '{ROW_RX,   8'h42,   1'b1, 2'd0, {NIL, NIL, NIL}},
        '{ROW_RX,   CH_BS,   1'b1, 2'd0, {NIL, NIL, NIL}},
        '{ROW_RX,   CH_BS,   1'b1, 2'd0, {NIL, NIL, NIL}},              // below empty
        '{ROW_RX,   CH_LF,   1'b1, 2'd3, {ECHO_CR, ECHO_LF, LINE_END}}
    };

    serial_line_editor_echo u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .rx_byte   (rx_byte),
        .full      (full),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .last      (last),
        .empty     (empty),
        .pop       (pop)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Editor model: one received byte in, the echo and line bytes out.
    function automatic void line_editor_step(input logic [7:0] c,
                                             ref line_out_t res [$]);
        res = {};
        if (c == NO_DATA || c == CH_CR)
            return;
        if (c == CH_LF)
        begin
            if (cur_pos == 0 || echo_on)
            begin
                res.push_back('{KIND_ECHO, CH_CR, 1'b0});
                res.push_back('{KIND_ECHO, CH_LF, 1'b0});
            end
            for (int i = 0; i < cur_pos; i++)
                res.push_back('{KIND_LINE, held_chars[i], 1'b0});
            res.push_back('{KIND_LINE, 8'h00, 1'b0});
            cur_pos = 0;
        end
        else if (c == CH_BS)
        begin
            if (echo_on)
            begin
                res.push_back('{KIND_ECHO, CH_BS, 1'b0});
                res.push_back('{KIND_ECHO, CH_SP, 1'b0});
                res.push_back('{KIND_ECHO, CH_BS, 1'b0});
            end
            if (cur_pos > 0)
                cur_pos--;
        end
        else
        begin
            if (echo_on)
                res.push_back('{KIND_ECHO, c, 1'b0});
            // cursor parks on the last slot once the line is full
            held_chars[cur_pos] = c;
            if (cur_pos < LINE_LEN - 1)
                cur_pos++;
        end
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
    endfunction

    // Offer one byte, with random idle cycles first; returns once the
    // transfer has happened, together with the model's output for it.
    task automatic send_rx(input logic [7:0] c, output line_out_t outs [$]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push    <= 1'b0;
            rx_byte <= 8'($urandom);     // junk while push is low
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        line_editor_step(c, outs);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (due_bytes.size() != 0)
            @(posedge clk);
    endtask

    // Idle the block: all results in, then let silent items finish.
    task automatic quiesce();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_echo(input logic on);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_we    <= 1'b0;
        echo_on = on;
    endtask

    // Random lines: mostly printable-or-not characters with a few BS,
    // CR and zero bytes mixed in, closed by LF. Some lines overrun the
    // store to exercise the full-line overwrite. Halfway through, the
    // sender stops until the output side has caught up.
    task automatic send_lines(input int quota);
        int         counted;
        int         len;
        int         r;
        bit         paused;
        logic [7:0] c;
        line_out_t  outs [$];
        counted = 0;
        paused  = 1'b0;
        while (counted < quota)
        begin
            if ($urandom_range(99) < 20)
                len = $urandom_range(LINE_LEN + 8, LINE_LEN - 4);
            else
                len = $urandom_range(12, 0);
            for (int k = 0; k <= len; k++)
            begin
                r = $urandom_range(99);
                if (k == len)
                    c = CH_LF;
                else if (r < 5)
                    c = 8'($urandom_range(255, 0));    // noise, LF included
                else if (r < 13)
                    c = CH_BS;
                else if (r < 16)
                    c = CH_CR;
                else if (r < 19)
                    c = NO_DATA;
                else
                begin
                    c = 8'($urandom_range(255, 1));
                    while (c == CH_CR || c == CH_LF || c == CH_BS)
                        c = 8'($urandom_range(255, 1));
                end
                send_rx(c, outs);
                foreach (outs[j])
                    due_bytes.push_back(outs[j]);
                counted++;
            end
            if (!paused && counted >= quota / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
        end
    endtask

    // Output side: check each transfer against the oldest expectation,
    // then pick pop for the next edge.
    initial
    begin
        line_out_t want;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (due_bytes.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: expected no result, got kind=%0d byte=%h last=%0d",
                             $time, out_kind, out_byte, last);
                end
                else
                begin
                    want = due_bytes.pop_front();
                    if (out_kind !== want.kind)
                    begin
                        err_cnt++;
                        $display("%0t: out_kind expected %0d, got %0d",
                                 $time, want.kind, out_kind);
                    end
                    if (out_byte !== want.data)
                    begin
                        err_cnt++;
                        $display("%0t: out_byte expected %h, got %h",
                                 $time, want.data, out_byte);
                    end
                    if (last !== want.last)
                    begin
                        err_cnt++;
                        $display("%0t: last expected %0d, got %0d",
                                 $time, want.last, last);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Main sequence
    initial
    begin
        line_out_t  outs [$];
        logic [8:0] pick;
        rst_n     = 1'b0;
        push      = 1'b0;
        rx_byte   = 8'h00;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_ECHO)
                set_echo(plan[i].data[0]);
            else
            begin
                send_rx(plan[i].data, outs);
                if (plan[i].typed)
                begin
                    outs = {};
                    for (int j = 0; j < plan[i].n; j++)
                    begin
                        pick = plan[i].r[j];
                        outs.push_back('{pick[8], pick[7:0], j == plan[i].n - 1});
                    end
                end
                foreach (outs[j])
                    due_bytes.push_back(outs[j]);
            end
        end

        // Phase 0 opens with a long receiver hold-off so the block backs
        // up and deasserts acceptance; otherwise nobody idles in phase 0.
        for (int p = 0; p < 4; p++)
        begin
            set_echo(phase_echo[p][0]);
            send_idle_pct = phase_send[p];
            stall_pct     = phase_stall[p];
            if (p == 0)
                hold_left = 400;
            send_lines(107);
        end

        quiesce();
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[serial_line_editor_echo.f]
rtl/sle_pkg.sv
rtl/sle_front.sv
rtl/sle_cmdq.sv
rtl/sle_back.sv
rtl/serial_line_editor_echo.sv
bench/tb_serial_line_editor_echo.sv
